FILE: rtl/ctsc_pkg.sv
// ----------------------------------------------------------------------------
// ctsc_pkg: shared types and constants of the C-style token classifier
// Token kind codes, scanner states and the result entry layout.
// ----------------------------------------------------------------------------
package ctsc_pkg;

  localparam int unsigned KindBits = 5;
  localparam int unsigned OutLenBits = 16;

  // Token kinds
  localparam logic [KindBits-1:0] K_END       = 5'd0;
  localparam logic [KindBits-1:0] K_SPACE     = 5'd1;
  localparam logic [KindBits-1:0] K_COMMENT   = 5'd2;
  localparam logic [KindBits-1:0] K_SLASH     = 5'd3;
  localparam logic [KindBits-1:0] K_ERR_END   = 5'd4;
  localparam logic [KindBits-1:0] K_STRING    = 5'd5;
  localparam logic [KindBits-1:0] K_CHAR      = 5'd6;
  localparam logic [KindBits-1:0] K_NUMBER    = 5'd7;
  localparam logic [KindBits-1:0] K_IDENT     = 5'd8;
  localparam logic [KindBits-1:0] K_ESCAPE    = 5'd9;
  localparam logic [KindBits-1:0] K_ESC_EXACT = 5'd10;
  localparam logic [KindBits-1:0] K_BACKSLASH = 5'd11;
  localparam logic [KindBits-1:0] K_PASTE     = 5'd12;
  localparam logic [KindBits-1:0] K_SYM_BANG  = 5'd13;
  localparam logic [KindBits-1:0] K_SYM_AMP   = 5'd14;
  localparam logic [KindBits-1:0] K_SYM_LPAR  = 5'd15;
  localparam logic [KindBits-1:0] K_SYM_RPAR  = 5'd16;
  localparam logic [KindBits-1:0] K_SYM_STAR  = 5'd17;
  localparam logic [KindBits-1:0] K_SYM_DOT   = 5'd18;
  localparam logic [KindBits-1:0] K_SYM_SEMI  = 5'd19;
  localparam logic [KindBits-1:0] K_SYM_LT    = 5'd20;
  localparam logic [KindBits-1:0] K_SYM_EQ    = 5'd21;
  localparam logic [KindBits-1:0] K_SYM_GT    = 5'd22;
  localparam logic [KindBits-1:0] K_SYM_LBR   = 5'd23;
  localparam logic [KindBits-1:0] K_SYM_BAR   = 5'd24;
  localparam logic [KindBits-1:0] K_SYM_RBR   = 5'd25;
  localparam logic [KindBits-1:0] K_ERROR     = 5'd26;

  // Exact-escape match progress
  localparam logic [2:0] MATCH_NONE = 3'd0;
  localparam logic [2:0] MATCH_AT   = 3'd1;
  localparam logic [2:0] MATCH_FULL = 3'd4;
  localparam logic [2:0] MATCH_FAIL = 3'd7;

  // Scanner states, one-hot
  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_SPACE   = 15'b000000000000010,
    S_SLASH   = 15'b000000000000100,
    S_LINE    = 15'b000000000001000,
    S_BLOCK   = 15'b000000000010000,
    S_BSTAR   = 15'b000000000100000,
    S_STR     = 15'b000000001000000,
    S_STR_ESC = 15'b000000010000000,
    S_CHR     = 15'b000000100000000,
    S_CHR_ESC = 15'b000001000000000,
    S_NUM     = 15'b000010000000000,
    S_IDENT   = 15'b000100000000000,
    S_AT      = 15'b001000000000000,
    S_BSL     = 15'b010000000000000,
    S_BSL_O   = 15'b100000000000000
  } scan_state_e;

  // One token result
  typedef struct packed {
    logic [KindBits-1:0]   kind;
    logic [OutLenBits-1:0] len;
  } tok_t;

  // All results caused by one request: first, and optionally a second
  typedef struct packed {
    logic two;
    tok_t r0;
    tok_t r1;
  } pair_t;

endpackage

FILE: rtl/ctsc_in_if.sv
// ----------------------------------------------------------------------------
// ctsc_in_if: byte request channel
// Valid/ready channel carrying one source byte or the end marker.
// ----------------------------------------------------------------------------
interface ctsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, output data_byte, output end_marker, input ready);
  modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

FILE: rtl/ctsc_out_if.sv
// ----------------------------------------------------------------------------
// ctsc_out_if: token result channel
// Valid/ready channel carrying one classified token.
// ----------------------------------------------------------------------------
interface ctsc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_length, input last_of_run,
                  output ready);
endinterface

FILE: rtl/ctsc_step.sv
// ----------------------------------------------------------------------------
// ctsc_step: scanner next-state logic
// Classifies one byte against the current scan state and yields the
// next state plus zero, one or two finished tokens.
// ----------------------------------------------------------------------------
module ctsc_step import ctsc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  scan_state_e            state_i,
  input  logic [2:0]             match_i,
  input  logic [LENGTH_BITS-1:0] len_i,
  input  logic [7:0]             byte_i,
  input  logic                   end_i,
  output scan_state_e            state_o,
  output logic [2:0]             match_o,
  output logic [LENGTH_BITS-1:0] len_o,
  output logic                   push_o,
  output pair_t                  pair_o
);

  localparam int unsigned ExtBits = (LENGTH_BITS > OutLenBits) ? LENGTH_BITS : OutLenBits;
  localparam logic [LENGTH_BITS-1:0] LenMax = '1;
  localparam logic [LENGTH_BITS-1:0] LenOne = LENGTH_BITS'(1);

  typedef struct packed {
    scan_state_e         st;
    logic                emit;
    logic [KindBits-1:0] kind;
    logic                at;
  } begin_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Classify the first byte of a new token
  function automatic begin_t begin_tok(input logic [7:0] c);
    begin_t b;
    b = '{st: S_IDLE, emit: 1'b0, kind: K_ERROR, at: 1'b0};
    priority if (is_blank(c))   b.st = S_SPACE;
    else if (c == 8'h2F)        b.st = S_SLASH;
    else if (c == 8'h22)        b.st = S_STR;
    else if (c == 8'h27)        b.st = S_CHR;
    else if (is_digit(c))       b.st = S_NUM;
    else if (is_word_start(c))  b.st = S_IDENT;
    else if (c == 8'h40) begin
      b.st = S_AT;
      b.at = 1'b1;
    end else if (c == 8'h5C)    b.st = S_BSL;
    else begin
      b.emit = 1'b1;
      unique case (c)
        8'h21:   b.kind = K_SYM_BANG;
        8'h26:   b.kind = K_SYM_AMP;
        8'h28:   b.kind = K_SYM_LPAR;
        8'h29:   b.kind = K_SYM_RPAR;
        8'h2A:   b.kind = K_SYM_STAR;
        8'h2E:   b.kind = K_SYM_DOT;
        8'h3B:   b.kind = K_SYM_SEMI;
        8'h3C:   b.kind = K_SYM_LT;
        8'h3D:   b.kind = K_SYM_EQ;
        8'h3E:   b.kind = K_SYM_GT;
        8'h7B:   b.kind = K_SYM_LBR;
        8'h7C:   b.kind = K_SYM_BAR;
        8'h7D:   b.kind = K_SYM_RBR;
        default: b.kind = K_ERROR;
      endcase
    end
    return b;
  endfunction

  // Clamp a count to the 16-bit result field
  function automatic logic [OutLenBits-1:0] sat_len(input logic [LENGTH_BITS-1:0] l);
    logic [ExtBits-1:0] w;
    w = ExtBits'(l);
    if (w > ExtBits'(17'h0FFFF)) return '1;
    return w[OutLenBits-1:0];
  endfunction

  logic [LENGTH_BITS-1:0] len_inc;
  logic [KindBits-1:0]    pend_kind;
  logic                   alnum;
  begin_t                 bt;

  assign len_inc = (len_i == LenMax) ? len_i : len_i + LenOne;
  assign alnum   = is_word_start(byte_i) || is_digit(byte_i);
  assign bt      = begin_tok(byte_i);

  // Kind of a pending token when it is cut off
  always_comb begin
    unique case (state_i)
      S_SPACE: pend_kind = K_SPACE;
      S_SLASH: pend_kind = K_SLASH;
      S_LINE:  pend_kind = K_COMMENT;
      S_NUM:   pend_kind = K_NUMBER;
      S_IDENT: pend_kind = K_IDENT;
      S_AT:    pend_kind = (match_i == MATCH_FULL) ? K_ESC_EXACT : K_ESCAPE;
      S_BSL:   pend_kind = K_BACKSLASH;
      S_BSL_O: pend_kind = K_ESCAPE;
      default: pend_kind = K_ERR_END;
    endcase
  end

  logic                fin;       // pending token finishes
  logic                fin_inc;   // finished token includes this byte
  logic [KindBits-1:0] fin_kind;
  logic                start;     // byte opens a new token
  logic                sec;       // second result (symbol, error or end)
  logic [KindBits-1:0] sec_kind;
  tok_t                fin_tok;
  tok_t                sec_tok;

  always_comb begin
    state_o  = state_i;
    match_o  = match_i;
    len_o    = len_i;
    fin      = 1'b0;
    fin_inc  = 1'b0;
    fin_kind = pend_kind;
    start    = 1'b0;
    sec      = 1'b0;
    sec_kind = K_END;

    if (end_i) begin
      // Flush pending token, then end
      fin     = (state_i != S_IDLE);
      sec     = 1'b1;
      state_o = S_IDLE;
      match_o = MATCH_NONE;
      len_o   = '0;
    end else begin
      unique case (state_i)
        S_SPACE: begin
          if (is_blank(byte_i)) len_o = len_inc;
          else begin
            fin   = 1'b1;
            start = 1'b1;
          end
        end
        S_SLASH: begin
          if (byte_i == 8'h2F) begin
            len_o   = len_inc;
            state_o = S_LINE;
          end else if (byte_i == 8'h2A) begin
            len_o   = len_inc;
            state_o = S_BLOCK;
          end else begin
            fin   = 1'b1;
            start = 1'b1;
          end
        end
        S_LINE: begin
          len_o = len_inc;
          if (byte_i == 8'h0A) begin
            fin      = 1'b1;
            fin_inc  = 1'b1;
          end
        end
        S_BLOCK: begin
          len_o = len_inc;
          if (byte_i == 8'h2A) state_o = S_BSTAR;
        end
        S_BSTAR: begin
          len_o = len_inc;
          if (byte_i == 8'h2F) begin
            fin      = 1'b1;
            fin_inc  = 1'b1;
            fin_kind = K_COMMENT;
          end else if (byte_i != 8'h2A) state_o = S_BLOCK;
        end
        S_STR: begin
          len_o = len_inc;
          if (byte_i == 8'h5C) state_o = S_STR_ESC;
          else if (byte_i == 8'h22) begin
            fin      = 1'b1;
            fin_inc  = 1'b1;
            fin_kind = K_STRING;
          end
        end
        S_STR_ESC: begin
          len_o   = len_inc;
          state_o = S_STR;
        end
        S_CHR: begin
          len_o = len_inc;
          if (byte_i == 8'h5C) state_o = S_CHR_ESC;
          else if (byte_i == 8'h27) begin
            fin      = 1'b1;
            fin_inc  = 1'b1;
            fin_kind = K_CHAR;
          end
        end
        S_CHR_ESC: begin
          len_o   = len_inc;
          state_o = S_CHR;
        end
        S_NUM, S_IDENT: begin
          if (alnum) len_o = len_inc;
          else begin
            fin   = 1'b1;
            start = 1'b1;
          end
        end
        S_AT: begin
          if (alnum) begin
            len_o = len_inc;
            // Advance the exact "@o2c" match
            unique case (match_i)
              3'd1:    match_o = (byte_i == 8'h6F) ? 3'd2 : MATCH_FAIL;
              3'd2:    match_o = (byte_i == 8'h32) ? 3'd3 : MATCH_FAIL;
              3'd3:    match_o = (byte_i == 8'h63) ? MATCH_FULL : MATCH_FAIL;
              default: match_o = MATCH_FAIL;
            endcase
          end else begin
            fin   = 1'b1;
            start = 1'b1;
          end
        end
        S_BSL: begin
          if (byte_i == 8'h5C) begin
            len_o    = len_inc;
            fin      = 1'b1;
            fin_inc  = 1'b1;
            fin_kind = K_PASTE;
          end else if (byte_i == 8'h6F) begin
            len_o   = len_inc;
            state_o = S_BSL_O;
          end else begin
            fin   = 1'b1;
            start = 1'b1;
          end
        end
        S_BSL_O: begin
          if (byte_i == 8'h6C) begin
            len_o    = len_inc;
            fin      = 1'b1;
            fin_inc  = 1'b1;
            fin_kind = K_ESC_EXACT;
          end else begin
            fin   = 1'b1;
            start = 1'b1;
          end
        end
        default: start = 1'b1;
      endcase

      // Drop the finished token's state
      if (fin) begin
        state_o = S_IDLE;
        match_o = MATCH_NONE;
        len_o   = '0;
      end

      // Open the next token on this byte
      if (start) begin
        state_o  = bt.st;
        len_o    = LenOne;
        sec      = bt.emit;
        sec_kind = bt.kind;
        if (bt.at) match_o = MATCH_AT;
      end
    end
  end

  assign fin_tok = '{kind: fin_kind, len: sat_len(fin_inc ? len_inc : len_i)};
  assign sec_tok = '{kind: sec_kind,
                     len: (end_i ? '0 : OutLenBits'(1))};

  assign push_o     = fin || sec;
  assign pair_o.two = fin && sec;
  assign pair_o.r0  = fin ? fin_tok : sec_tok;
  assign pair_o.r1  = sec_tok;

endmodule

FILE: rtl/ctsc_outq.sv
// ----------------------------------------------------------------------------
// ctsc_outq: result queue
// Two-entry queue of per-request result pairs, one token out per ready cycle.
// ----------------------------------------------------------------------------
module ctsc_outq import ctsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pair_t      pair_i,
  output logic       space_o,
  ctsc_out_if.source out_o
);

  pair_t      ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       sub_q, sub_d;
  pair_t      head;
  logic       take;
  logic       pop;

  assign head = ent_q[rd_ptr_q];
  assign take = out_o.valid && out_o.ready;
  assign pop  = take && (sub_q || !head.two);

  // Present the head entry, second token after the first
  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.token_kind   = sub_q ? head.r1.kind : head.r0.kind;
  assign out_o.token_length = sub_q ? head.r1.len : head.r0.len;
  assign out_o.last_of_run  = sub_q || !head.two;

  // Room for one more entry, counting the one leaving this cycle
  assign space_o = (cnt_q != 2'd2) || pop;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
    sub_d    = sub_q;
    if (take) sub_d = head.two && !sub_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      sub_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      sub_q    <= sub_d;
    end
  end

  // Store entry payload
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= pair_i;
  end

endmodule

FILE: rtl/c_style_token_classifier_core.sv
// ----------------------------------------------------------------------------
// c_style_token_classifier_core: C-style token classifier
// Groups a byte stream into C-like tokens and reports kind and length.
// ----------------------------------------------------------------------------
//
//   Port    Dir  Handshake     Payload
//   req_i   in   valid/ready   data_byte[7:0], end_marker
//   rsp_o   out  valid/ready   token_kind[4:0], token_length[15:0], last_of_run
//
// One byte is taken per ready cycle; the scan state updates on the same edge.
// Each request yields zero, one or two tokens, queued in a two-entry result
// queue that drains one token per ready cycle, so two-token requests slow the
// input to the output rate. Reset clears the scan state and the queue.
// req_i.ready drops only while the queue is full and its head does not leave.
// ----------------------------------------------------------------------------
module c_style_token_classifier_core import ctsc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctsc_in_if.sink    req_i,
  ctsc_out_if.source rsp_o
);

  scan_state_e            state_q, state_d;
  logic [2:0]             match_q, match_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   push;
  logic                   space;
  logic                   accept;
  pair_t                  pair;

  assign req_i.ready = space;
  assign accept      = req_i.valid && space;

  // Classify the byte against the current state
  ctsc_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .state_i (state_q),
    .match_i (match_q),
    .len_i   (len_q),
    .byte_i  (req_i.data_byte),
    .end_i   (req_i.end_marker),
    .state_o (state_d),
    .match_o (match_d),
    .len_o   (len_d),
    .push_o  (push),
    .pair_o  (pair)
  );

  // Advance scan state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      match_q <= MATCH_NONE;
      len_q   <= '0;
    end else if (accept) begin
      state_q <= state_d;
      match_q <= match_d;
      len_q   <= len_d;
    end
  end

  // Hold finished tokens until taken
  ctsc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && push),
    .pair_i  (pair),
    .space_o (space),
    .out_o   (rsp_o)
  );

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the C-style token classifier
// Drives bytes and end markers through the request channel with bursts and
// gaps, stalls the token channel on its own pattern, and compares every token
// against an in-bench scanner model or typed-in tokens. A directed table and
// a long line comment come first, then random C-like text mixed with noise.
// ----------------------------------------------------------------------------
module tb_top import ctsc_pkg::*; ();

  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned LengthBits   = 16;
  localparam int unsigned LimitCycles  = 1_000_000;
  localparam int unsigned RandItems    = 870;
  localparam int unsigned LongBody     = 200;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PrintCap     = 40;
  localparam int unsigned DirRows      = 30;
  localparam longint unsigned CntMax   = (64'd1 << LengthBits) - 1;

  // Receiver stall modes
  localparam int unsigned RxOpen   = 0;
  localparam int unsigned RxRandom = 1;
  localparam int unsigned RxPulse  = 2;
  localparam int unsigned RxBlocks = 3;

  // One request, with optional typed-in tokens (n_fix == 0: use the model)
  typedef struct packed {
    logic [7:0] b;
    logic       eom;
    logic [1:0] n_fix;
    tok_t       fix0;
    tok_t       fix1;
  } stim_row_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] len;
    logic        last;
  } tok_rec_t;

  logic clk_i;
  logic rst_ni;

  ctsc_in_if  req_if ();
  ctsc_out_if rsp_if ();

  c_style_token_classifier_core #(
    .LENGTH_BITS(LengthBits)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Scanner model state
  scan_state_e     scan_q  = S_IDLE;
  logic [2:0]      match_q = MATCH_NONE;
  longint unsigned cnt_q   = 0;
  tok_t            tok_buf [2];
  int unsigned     tok_n;

  localparam logic [31:0] AtWord = "@o2c";

  tok_rec_t    pending_toks [$];
  logic [8:0]  frag_q [$];
  stim_row_t   cur_row;
  int unsigned miss_count = 0;
  int unsigned tok_seen = 0;
  int unsigned items_taken = 0;
  int unsigned kind_hits [32];
  int unsigned burst_left = 0;
  int unsigned stall_mode = RxOpen;
  int unsigned mode_left = 0;

  logic [7:0] sym_bytes [13] = '{"!", "&", "(", ")", "*", ".", ";", "<", "=", ">", "{", "|", "}"};
  logic [7:0] ws_bytes [4] = '{" ", "\t", "\r", "\n"};

  // Directed table: typed tokens where they are obvious, model elsewhere
  stim_row_t dir_tab [DirRows] = '{
    '{"/",   1'b1, 2'd1, '{K_END, 16'd0},     '0},
    '{8'h00, 1'b0, 2'd1, '{K_ERROR, 16'd1},   '0},
    '{8'hFF, 1'b0, 2'd1, '{K_ERROR, 16'd1},   '0},
    '{"!",   1'b0, 2'd1, '{K_SYM_BANG, 16'd1}, '0},
    '{"\"",  1'b0, 2'd0, '0, '0},
    '{"\\",  1'b0, 2'd0, '0, '0},
    '{"\"",  1'b0, 2'd0, '0, '0},
    '{"\"",  1'b0, 2'd0, '0, '0},
    '{"/",   1'b0, 2'd0, '0, '0},
    '{"*",   1'b0, 2'd0, '0, '0},
    '{"/",   1'b0, 2'd0, '0, '0},
    '{"*",   1'b0, 2'd0, '0, '0},
    '{"/",   1'b0, 2'd0, '0, '0},
    '{"\\",  1'b0, 2'd0, '0, '0},
    '{"o",   1'b0, 2'd0, '0, '0},
    '{"l",   1'b0, 2'd0, '0, '0},
    '{"\\",  1'b0, 2'd0, '0, '0},
    '{"\\",  1'b0, 2'd0, '0, '0},
    '{"\\",  1'b0, 2'd0, '0, '0},
    '{"o",   1'b0, 2'd0, '0, '0},
    '{"@",   1'b0, 2'd0, '0, '0},
    '{"o",   1'b0, 2'd0, '0, '0},
    '{"2",   1'b0, 2'd0, '0, '0},
    '{"c",   1'b0, 2'd0, '0, '0},
    '{" ",   1'b0, 2'd0, '0, '0},
    '{"/",   1'b0, 2'd0, '0, '0},
    '{"/",   1'b0, 2'd0, '0, '0},
    '{8'h5A, 1'b1, 2'd0, '0, '0},
    '{"'",   1'b0, 2'd0, '0, '0},
    '{8'hA5, 1'b1, 2'd2, '{K_ERR_END, 16'd1}, '{K_END, 16'd0}}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("timeout with %0d tokens still awaited", pending_toks.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------

  function automatic bit is_ws(input logic [7:0] c);
    return c == " " || c == "\t" || c == "\r" || c == "\n";
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  task automatic emit(input logic [4:0] kind, input longint unsigned len);
    tok_buf[tok_n].kind = kind;
    tok_buf[tok_n].len  = (len > 64'hFFFF) ? 16'hFFFF : len[15:0];
    tok_n++;
  endtask

  task automatic bump();
    if (cnt_q < CntMax) cnt_q++;
  endtask

  task automatic close_token(input logic [4:0] kind);
    emit(kind, cnt_q);
    scan_q  = S_IDLE;
    cnt_q   = 0;
    match_q = MATCH_NONE;
  endtask

  // Kind of the token still open when it is cut short
  function automatic logic [4:0] held_kind();
    case (scan_q)
      S_SPACE: return K_SPACE;
      S_SLASH: return K_SLASH;
      S_LINE:  return K_COMMENT;
      S_NUM:   return K_NUMBER;
      S_IDENT: return K_IDENT;
      S_AT:    return (match_q == MATCH_FULL) ? K_ESC_EXACT : K_ESCAPE;
      S_BSL:   return K_BACKSLASH;
      S_BSL_O: return K_ESCAPE;
      default: return K_ERR_END;
    endcase
  endfunction

  task automatic open_token(input logic [7:0] c);
    cnt_q  = 1;
    scan_q = S_IDLE;
    if (is_ws(c)) scan_q = S_SPACE;
    else if (c == "/") scan_q = S_SLASH;
    else if (c == "\"") scan_q = S_STR;
    else if (c == "'") scan_q = S_CHR;
    else if (is_digit(c)) scan_q = S_NUM;
    else if (is_letter(c)) scan_q = S_IDENT;
    else if (c == "@") begin
      scan_q  = S_AT;
      match_q = MATCH_AT;
    end else if (c == "\\") scan_q = S_BSL;
    else begin
      case (c)
        "!":     emit(K_SYM_BANG, 1);
        "&":     emit(K_SYM_AMP, 1);
        "(":     emit(K_SYM_LPAR, 1);
        ")":     emit(K_SYM_RPAR, 1);
        "*":     emit(K_SYM_STAR, 1);
        ".":     emit(K_SYM_DOT, 1);
        ";":     emit(K_SYM_SEMI, 1);
        "<":     emit(K_SYM_LT, 1);
        "=":     emit(K_SYM_EQ, 1);
        ">":     emit(K_SYM_GT, 1);
        "{":     emit(K_SYM_LBR, 1);
        "|":     emit(K_SYM_BAR, 1);
        "}":     emit(K_SYM_RBR, 1);
        default: emit(K_ERROR, 1);
      endcase
    end
  endtask

  // Advance the scanner by one request; tokens land in tok_buf
  task automatic classify_byte(input logic [7:0] c, input logic eom);
    tok_n = 0;
    if (eom) begin
      if (scan_q != S_IDLE) close_token(held_kind());
      emit(K_END, 0);
      scan_q  = S_IDLE;
      match_q = MATCH_NONE;
      cnt_q   = 0;
    end else begin
      case (scan_q)
        S_SPACE: begin
          if (is_ws(c)) bump();
          else begin
            close_token(K_SPACE);
            open_token(c);
          end
        end
        S_SLASH: begin
          if (c == "/") begin
            bump();
            scan_q = S_LINE;
          end else if (c == "*") begin
            bump();
            scan_q = S_BLOCK;
          end else begin
            close_token(K_SLASH);
            open_token(c);
          end
        end
        S_LINE: begin
          bump();
          if (c == "\n") close_token(K_COMMENT);
        end
        S_BLOCK: begin
          bump();
          if (c == "*") scan_q = S_BSTAR;
        end
        S_BSTAR: begin
          bump();
          if (c == "/") close_token(K_COMMENT);
          else if (c != "*") scan_q = S_BLOCK;
        end
        S_STR: begin
          bump();
          if (c == "\\") scan_q = S_STR_ESC;
          else if (c == "\"") close_token(K_STRING);
        end
        S_STR_ESC: begin
          bump();
          scan_q = S_STR;
        end
        S_CHR: begin
          bump();
          if (c == "\\") scan_q = S_CHR_ESC;
          else if (c == "'") close_token(K_CHAR);
        end
        S_CHR_ESC: begin
          bump();
          scan_q = S_CHR;
        end
        S_NUM, S_IDENT: begin
          if (is_letter(c) || is_digit(c)) bump();
          else begin
            close_token(held_kind());
            open_token(c);
          end
        end
        S_AT: begin
          if (is_letter(c) || is_digit(c)) begin
            bump();
            if (match_q < MATCH_FULL && c == AtWord[8*(3-match_q) +: 8])
              match_q = match_q + 3'd1;
            else match_q = MATCH_FAIL;
          end else begin
            close_token(held_kind());
            open_token(c);
          end
        end
        S_BSL: begin
          if (c == "\\") begin
            bump();
            close_token(K_PASTE);
          end else if (c == "o") begin
            bump();
            scan_q = S_BSL_O;
          end else begin
            close_token(K_BACKSLASH);
            open_token(c);
          end
        end
        S_BSL_O: begin
          if (c == "l") begin
            bump();
            close_token(K_ESC_EXACT);
          end else begin
            close_token(K_ESCAPE);
            open_token(c);
          end
        end
        default: open_token(c);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_miss(input string what, input longint unsigned want,
                             input longint unsigned got);
    miss_count++;
    if (miss_count <= PrintCap)
      $display("[%0t] token %0d %s: want %0d got %0d", $time, tok_seen, what, want, got);
  endtask

  // Predict on each accepted request, then compare each accepted token
  always @(posedge clk_i) begin
    tok_rec_t want;
    if (rst_ni && req_if.valid && req_if.ready) begin
      classify_byte(req_if.data_byte, req_if.end_marker);
      if (cur_row.n_fix != 2'd0) begin
        tok_n      = cur_row.n_fix;
        tok_buf[0] = cur_row.fix0;
        tok_buf[1] = cur_row.fix1;
      end
      for (int i = 0; i < tok_n; i++)
        pending_toks.push_back('{tok_buf[i].kind, tok_buf[i].len, i == tok_n - 1});
      items_taken++;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      kind_hits[rsp_if.token_kind]++;
      if (pending_toks.size() == 0) begin
        report_miss("arrived with none awaited, kind", 0, rsp_if.token_kind);
      end else begin
        want = pending_toks.pop_front();
        if (rsp_if.token_kind !== want.kind) report_miss("kind", want.kind, rsp_if.token_kind);
        if (rsp_if.token_length !== want.len) report_miss("length", want.len, rsp_if.token_length);
        if (rsp_if.last_of_run !== want.last) report_miss("last", want.last, rsp_if.last_of_run);
      end
      tok_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Token receiver: switch between open, random, pulsed and blocked stretches
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(RxOpen, RxBlocks);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (stall_mode)
      RxOpen:   rsp_if.ready <= 1'b1;
      RxRandom: rsp_if.ready <= ($urandom_range(0, 9) < 7);
      RxPulse:  rsp_if.ready <= (mode_left % 4 != 0);
      default:  rsp_if.ready <= ((mode_left / 12) % 2 == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  function automatic stim_row_t plain_row(input logic [7:0] b, input logic eom);
    stim_row_t r;
    r     = '0;
    r.b   = b;
    r.eom = eom;
    return r;
  endfunction

  // Present one request and hold it until taken
  task automatic drive_row(input stim_row_t r);
    @(negedge clk_i);
    req_if.valid      <= 1'b1;
    req_if.data_byte  <= r.b;
    req_if.end_marker <= r.eom;
    cur_row = r;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Drop valid, with junk on the payload
  task automatic hold_input(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      req_if.valid      <= 1'b0;
      req_if.data_byte  <= 8'($urandom_range(0, 255));
      req_if.end_marker <= 1'($urandom_range(0, 1));
    end
  endtask

  // Send in bursts of random length with random gaps between them
  task automatic send_paced(input stim_row_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) hold_input($urandom_range(1, 6));
    end
    burst_left--;
    drive_row(r);
  endtask

  // Stop sending until every awaited token is in, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_toks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random C-like text
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] word_char(input int unsigned i);
    if (i < 26) return 8'("a" + i);
    if (i < 52) return 8'("A" + i - 26);
    if (i == 52) return "_";
    return 8'("0" + i - 53);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    frag_q.push_back({1'b0, b});
  endtask

  task automatic add_word(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Append one token-sized piece of text (or noise, or an end marker)
  task automatic queue_fragment();
    int unsigned pick;
    logic [7:0]  quote;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 4)) add_byte(ws_bytes[$urandom_range(0, 3)]);
    end else if (pick < 22) begin
      add_byte(word_char($urandom_range(0, 52)));
      repeat ($urandom_range(0, 6)) add_byte(word_char($urandom_range(0, 62)));
    end else if (pick < 29) begin
      add_byte(word_char($urandom_range(53, 62)));
      repeat ($urandom_range(0, 4)) add_byte(word_char($urandom_range(0, 62)));
    end else if (pick < 38) begin
      // string or char literal, escapes included
      quote = (pick < 34) ? "\"" : "'";
      add_byte(quote);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 3) == 0) begin
          add_byte("\\");
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1) == 0) b = ($urandom_range(0, 1) == 0) ? quote : "\\";
          add_byte(b);
        end else begin
          b = 8'($urandom_range(0, 255));
          if (b == quote || b == "\\") b = "x";
          add_byte(b);
        end
      end
      add_byte(quote);
    end else if (pick < 44) begin
      add_word("//");
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(0, 255));
        if (b == "\n") b = " ";
        add_byte(b);
      end
      add_byte("\n");
    end else if (pick < 50) begin
      add_word("/*");
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 2) == 0) add_byte("*");
        else if ($urandom_range(0, 3) == 0) add_byte("/");
        else add_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0) add_byte("*");
      add_word("*/");
    end else if (pick < 60) begin
      add_byte(sym_bytes[$urandom_range(0, 12)]);
    end else if (pick < 67) begin
      add_byte("@");
      case ($urandom_range(0, 4))
        0: add_word("o2c");
        1: add_word("o2");
        2: begin
          add_word("o2c");
          add_byte(word_char($urandom_range(0, 62)));
        end
        3: repeat ($urandom_range(0, 4)) add_byte(word_char($urandom_range(0, 62)));
        default: add_word("o2d");
      endcase
    end else if (pick < 74) begin
      add_byte("\\");
      case ($urandom_range(0, 3))
        0: add_byte("\\");
        1: add_word("ol");
        2: begin
          add_byte("o");
          b = 8'($urandom_range(0, 255));
          if (b == "l") b = "m";
          add_byte(b);
        end
        default: begin
          b = 8'($urandom_range(0, 255));
          if (b == "\\" || b == "o") b = " ";
          add_byte(b);
        end
      endcase
    end else if (pick < 78) begin
      add_byte("/");
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      frag_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    end else begin
      // literal or block comment cut off by the end marker
      case ($urandom_range(0, 2))
        0: add_word("/*");
        1: add_byte("\"");
        default: add_byte("'");
      endcase
      repeat ($urandom_range(0, 4)) add_byte(word_char($urandom_range(0, 62)));
      frag_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  lb;
    int unsigned rand_items;
    bit          mid_drained;
    int unsigned kinds_seen;

    rand_items  = 0;
    mid_drained = 1'b0;
    kinds_seen  = 0;
    foreach (kind_hits[i]) kind_hits[i] = 0;
    cur_row           = '0;
    req_if.valid      = 1'b0;
    req_if.data_byte  = 8'h00;
    req_if.end_marker = 1'b0;
    rsp_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (dir_tab[i]) send_paced(dir_tab[i]);
    drain();

    // Long line comment sent back to back
    drive_row(plain_row("/", 1'b0));
    drive_row(plain_row("/", 1'b0));
    repeat (LongBody) begin
      lb = 8'($urandom_range(0, 255));
      if (lb == "\n") lb = 8'h0B;
      drive_row(plain_row(lb, 1'b0));
    end
    drive_row(plain_row("\n", 1'b0));
    drain();

    // Random text, with one full pause halfway
    while (rand_items < RandItems) begin
      frag_q.delete();
      queue_fragment();
      foreach (frag_q[i]) begin
        send_paced(plain_row(frag_q[i][7:0], frag_q[i][8]));
        rand_items++;
      end
      if (!mid_drained && rand_items >= RandItems / 2) begin
        drain();
        mid_drained = 1'b1;
      end
    end
    send_paced(plain_row(8'($urandom_range(0, 255)), 1'b1));
    drain();

    foreach (kind_hits[i]) if (kind_hits[i] != 0) kinds_seen++;
    $display("%0d requests (table, long comment, random text) gave %0d tokens",
             items_taken, tok_seen);
    $display("%0d distinct token kinds seen, %0d mismatches", kinds_seen, miss_count);
    if (miss_count == 0 && pending_toks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
